[hw/rtl/maor_pkg.sv]
// ----------------------------------------------------------------------------
// maor_pkg
// Shared types and constants for the moving average with outlier rejection.
// ----------------------------------------------------------------------------
package maor_pkg;

  // Field and state widths.
  localparam int DEPTH_DEF = 64;
  localparam int DEPTH_MAX = 64;
  localparam int SAMPLE_W  = 24;
  localparam int SUM_W     = 30;
  localparam int SQSUM_W   = 53;
  localparam int MULT_W    = 4;
  localparam int LIMIT_W   = 8;
  localparam int REJ_W     = 8;
  localparam int AVG_W     = 32;
  localparam int FRAC_W    = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  // Divider sizes: count never exceeds DEPTH_MAX.
  localparam int CNT_W     = $clog2(DEPTH_MAX + 1);
  localparam int DVD_W     = SUM_W + FRAC_W;

  // Shared multiplier and wide compare widths.
  localparam int MUL_W     = 32;
  localparam int WIDE_W    = 2 * SUM_W - 1;
  localparam int M2_W      = 2 * MULT_W;
  localparam int RHS_W     = WIDE_W + M2_W;

  // Register reset values.
  localparam logic [MULT_W-1:0]  SIGMA_MULT_RST   = MULT_W'(3);
  localparam logic [LIMIT_W-1:0] REJECT_LIMIT_RST = LIMIT_W'(5);
  localparam logic [REJ_W-1:0]   REJ_MAX          = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_MULT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REJECT_LIMIT = CFG_IDX_W'(1);

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_SQSUM,
    ST_SD,
    ST_P0,
    ST_P1,
    ST_V,
    ST_MM,
    ST_K0,
    ST_K1,
    ST_CMP,
    ST_SS,
    ST_OO,
    ST_UPD,
    ST_DIV,
    ST_OUT
  } state_t;

  // Divider request and result.
  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [AVG_W-1:0]  quot;
  } div_res_t;

endpackage

[hw/rtl/maor_div.sv]
// ----------------------------------------------------------------------------
// maor_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module maor_div
  import maor_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_res_t res
);

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W-1:0]  rem_r;
  logic [DVD_W-1:0]  dq_r;
  logic [CNT_W:0]    rem_sh;
  logic              q_bit;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    rem_sh = {rem_r, dq_r[DVD_W-1]};
    q_bit  = (rem_sh >= {1'b0, dvs_r});
  end

  // Control: busy for DVD_W steps, done pulses after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dq_r  <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dq_r  <= {dq_r[DVD_W-2:0], q_bit};
      rem_r <= q_bit ? CNT_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[CNT_W-1:0];
    end
  end

  assign res.done = done_r;
  assign res.quot = dq_r[AVG_W-1:0];

endmodule

[hw/rtl/moving_average_outlier_reject.sv]
// ----------------------------------------------------------------------------
// moving_average_outlier_reject
// Moving average over a ring of samples with sigma-based outlier rejection.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. The time a sample takes depends on
// its path: forced in (ring not yet wrapped, or reject limit exceeded),
// put through the sigma test and stored, or rejected. It is set by the 38-step
// bit-serial divider that forms the Q8 average, plus up to ten passes
// through the one shared 32x32 multiplier for the squared sigma test and
// the sum-of-squares update.
// in_ready is high only while the sequencer is idle; a finished result sits
// in the output register, so the next sample can be taken before it is read.
// The ring memory needs no clearing pass: entries past the write pointer read
// as zero until the ring has wrapped.
module moving_average_outlier_reject
  import maor_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Sample channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_clear,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_accepted,
  output logic signed [AVG_W-1:0]    out_average_q8,
  output logic                       out_filled,
  output logic [REJ_W-1:0]           out_rejects,
  // Configuration
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata
);

  localparam int PTR_W = $clog2(DEPTH);

  state_t state_r, state_nxt;

  // Block state.
  logic [PTR_W-1:0]           wp_r;
  logic                       filled_r;
  logic [REJ_W-1:0]           rej_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [SQSUM_W-1:0]         sum2_r;
  logic [MULT_W-1:0]          sig_mult_r;
  logic [LIMIT_W-1:0]         limit_r;

  // Working registers.
  logic signed [SAMPLE_W-1:0] s_r;
  logic signed [SAMPLE_W-1:0] old_r;
  logic [SAMPLE_W-1:0]        rdata_r;
  logic [WIDE_W-1:0]          q_r;
  logic [SUM_W-1:0]           d_r;
  logic [WIDE_W-1:0]          p_r;
  logic [WIDE_W-1:0]          v_r;
  logic [WIDE_W-1:0]          lhs_r;
  logic [M2_W-1:0]            m2_r;
  logic [MUL_W+M2_W-1:0]      rhs_r;
  logic [2*MUL_W-1:0]         prod_r;
  logic                       acc_r;

  // Output register.
  logic                       out_valid_r;
  logic                       out_accepted_r;
  logic signed [AVG_W-1:0]    out_avg_r;
  logic                       out_filled_r;
  logic [REJ_W-1:0]           out_rej_r;

  logic [SAMPLE_W-1:0]        ring_mem [DEPTH];

  // Combinational helpers.
  logic                       in_fire;
  logic                       force_in;
  logic                       mem_we;
  logic                       out_load;
  logic                       empty;
  logic                       pass;
  logic [SAMPLE_W-1:0]        abs_s;
  logic [SAMPLE_W-1:0]        abs_old;
  logic [SUM_W-1:0]           abs_sum;
  logic [SUM_W-1:0]           sd;
  logic [RHS_W-1:0]           rhs_full;
  logic [MUL_W-1:0]           mul_a;
  logic [MUL_W-1:0]           mul_b;
  logic [CNT_W-1:0]           count;
  logic [AVG_W-1:0]           avg_mag;
  logic signed [AVG_W-1:0]    avg_nxt;
  div_req_t                   div_req;
  div_res_t                   div_res;

  // Magnitudes and derived values.
  always_comb begin
    in_fire  = in_valid && in_ready;
    force_in = !filled_r || (rej_r > limit_r);
    empty    = !filled_r && (wp_r == '0);
    abs_s    = s_r[SAMPLE_W-1] ? SAMPLE_W'(-s_r) : SAMPLE_W'(s_r);
    abs_old  = old_r[SAMPLE_W-1] ? SAMPLE_W'(-old_r) : SAMPLE_W'(old_r);
    abs_sum  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    sd       = prod_r[SUM_W-1:0];
    rhs_full = RHS_W'(rhs_r) + {prod_r[RHS_W-MUL_W-1:0], {MUL_W{1'b0}}};
    pass     = (RHS_W'(lhs_r) < rhs_full);
    count    = filled_r ? CNT_W'(DEPTH) : CNT_W'(wp_r);
    avg_mag  = div_res.quot;
    avg_nxt  = empty ? '0 : (sum_r[SUM_W-1] ? AVG_W'(-avg_mag) : AVG_W'(avg_mag));
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQSUM: begin
        mul_a = MUL_W'(abs_sum);
        mul_b = MUL_W'(abs_sum);
      end
      ST_SD: begin
        mul_a = MUL_W'(abs_s);
        mul_b = MUL_W'(DEPTH);
      end
      ST_P0: begin
        mul_a = sum2_r[MUL_W-1:0];
        mul_b = MUL_W'(DEPTH);
      end
      ST_P1: begin
        mul_a = MUL_W'(sum2_r[SQSUM_W-1:MUL_W]);
        mul_b = MUL_W'(DEPTH);
      end
      ST_V: begin
        mul_a = MUL_W'(d_r);
        mul_b = MUL_W'(d_r);
      end
      ST_MM: begin
        mul_a = MUL_W'(sig_mult_r);
        mul_b = MUL_W'(sig_mult_r);
      end
      ST_K0: begin
        mul_a = MUL_W'(prod_r[M2_W-1:0]);
        mul_b = v_r[MUL_W-1:0];
      end
      ST_K1: begin
        mul_a = MUL_W'(m2_r);
        mul_b = MUL_W'(v_r[WIDE_W-1:MUL_W]);
      end
      ST_SS: begin
        mul_a = MUL_W'(abs_s);
        mul_b = MUL_W'(abs_s);
      end
      ST_OO: begin
        mul_a = MUL_W'(abs_old);
        mul_b = MUL_W'(abs_old);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and control strobes.
  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    mem_we          = 1'b0;
    out_load        = 1'b0;
    div_req.start   = 1'b0;
    div_req.dividend = {abs_sum, {FRAC_W{1'b0}}};
    div_req.divisor = count;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_clear) begin
            state_nxt = ST_CLR;
          end else if (force_in) begin
            state_nxt = ST_SS;
          end else begin
            state_nxt = ST_SQSUM;
          end
        end
      end
      ST_CLR:   state_nxt = ST_OUT;
      ST_SQSUM: state_nxt = ST_SD;
      ST_SD:    state_nxt = ST_P0;
      ST_P0:    state_nxt = ST_P1;
      ST_P1:    state_nxt = ST_V;
      ST_V:     state_nxt = ST_MM;
      ST_MM:    state_nxt = ST_K0;
      ST_K0:    state_nxt = ST_K1;
      ST_K1:    state_nxt = ST_CMP;
      ST_CMP: begin
        if (pass) begin
          state_nxt = ST_SS;
        end else begin
          state_nxt     = ST_DIV;
          div_req.start = !empty;
        end
      end
      ST_SS:    state_nxt = ST_OO;
      ST_OO:    state_nxt = ST_UPD;
      ST_UPD: begin
        mem_we    = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // Sums are final here; start the division unless the ring is empty.
        if (empty) begin
          state_nxt = ST_OUT;
        end else if (div_res.done) begin
          state_nxt = ST_OUT;
        end
        div_req.start = 1'b0;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
    // The division is launched on entry to ST_DIV, from the update step or a failed compare.
    if (state_r == ST_UPD) begin
      div_req.start = 1'b0;
    end
  end

  // Launch the division through a register, so that it starts once the sums have settled.
  logic div_go_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= (state_r == ST_UPD) || ((state_r == ST_CMP) && !pass);
    end
  end

  div_req_t div_req_q;
  always_comb begin
    div_req_q       = div_req;
    div_req_q.start = div_go_r && !empty;
  end

  maor_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_q),
    .res   (div_res)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_mult_r <= SIGMA_MULT_RST;
      limit_r    <= REJECT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIGMA_MULT:   sig_mult_r <= cfg_wdata[MULT_W-1:0];
        REG_REJECT_LIMIT: limit_r    <= cfg_wdata[LIMIT_W-1:0];
      endcase
    end
  end

  // Ring memory: written at the pointer, read every cycle at the pointer.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wp_r] <= s_r;
    end
    rdata_r <= ring_mem[wp_r];
  end

  // Ring state, sums and reject count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      filled_r <= 1'b0;
      rej_r    <= '0;
      sum_r    <= '0;
      sum2_r   <= '0;
    end else begin
      case (state_r)
        ST_CLR: begin
          wp_r     <= '0;
          filled_r <= 1'b0;
          sum_r    <= '0;
          sum2_r   <= '0;
        end
        ST_CMP: begin
          if (!pass && (rej_r != REJ_MAX)) begin
            rej_r <= rej_r + REJ_W'(1);
          end
        end
        ST_OO: begin
          sum2_r <= sum2_r + SQSUM_W'(prod_r[2*SAMPLE_W-1:0]);
        end
        ST_UPD: begin
          sum2_r <= sum2_r - SQSUM_W'(prod_r[2*SAMPLE_W-1:0]);
          sum_r  <= sum_r + SUM_W'(s_r) - SUM_W'(old_r);
          rej_r  <= '0;
          if (wp_r == PTR_W'(DEPTH - 1)) begin
            wp_r     <= '0;
            filled_r <= 1'b1;
          end else begin
            wp_r <= wp_r + PTR_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of the sigma test and the update.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_r   <= in_sample;
      acc_r <= 1'b0;
    end
    case (state_r)
      ST_SD:  q_r   <= prod_r[WIDE_W-1:0];
      ST_P0:  d_r   <= (sd >= abs_sum) ? (sd - abs_sum) : (abs_sum - sd);
      ST_P1:  p_r   <= WIDE_W'(prod_r[MUL_W+CNT_W-1:0]);
      ST_V:   p_r   <= p_r + {prod_r[WIDE_W-MUL_W-1:0], {MUL_W{1'b0}}};
      ST_MM: begin
        v_r   <= (p_r >= q_r) ? (p_r - q_r) : '0;
        lhs_r <= prod_r[WIDE_W-1:0];
      end
      ST_K0:  m2_r  <= prod_r[M2_W-1:0];
      ST_K1:  rhs_r <= prod_r[MUL_W+M2_W-1:0];
      ST_SS:  old_r <= filled_r ? rdata_r : '0;
      ST_UPD: acc_r <= 1'b1;
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_accepted_r <= acc_r;
      out_avg_r      <= avg_nxt;
      out_filled_r   <= filled_r;
      out_rej_r      <= rej_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_average_q8 = out_avg_r;
  assign out_filled     = out_filled_r;
  assign out_rejects    = out_rej_r;

endmodule

[hw/rtl/maor_checker.sv]
// ----------------------------------------------------------------------------
// maor_checker
// Port-level checks for the moving average with outlier rejection.
// ----------------------------------------------------------------------------
module maor_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic [31:0] out_average_q8,
  input logic        out_filled,
  input logic [7:0]  out_rejects
);

  // A held result stays valid and unchanged until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average_q8) &&
      $stable(out_accepted) && $stable(out_filled) && $stable(out_rejects))
    else $error("held result changed before it was taken");

  // The block works on one transaction at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in progress");

  // A stored sample always resets the reject count.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_rejects == 8'd0)
    else $error("accepted sample with nonzero reject count");

  // No result is shown right after reset.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind moving_average_outlier_reject maor_checker u_maor_checker (.*);

[tb/moving_average_outlier_reject_tb.sv]
// ----------------------------------------------------------------------------
// moving_average_outlier_reject_tb
// Self-checking testbench for the moving average with outlier rejection.
// A behavioral predictor follows every sample and clear accepted by the block
// and queues the expected result. Each result transaction is checked field by
// field against the oldest entry. Stimulus is a short directed run followed
// by random operating points under several rejection settings, with random
// idling on both channels.
// ----------------------------------------------------------------------------
module moving_average_outlier_reject_tb;
  import maor_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic                    accepted;
    logic signed [AVG_W-1:0] average_q8;
    logic                    filled;
    logic [REJ_W-1:0]        rejects;
  } avg_result_t;

  // DUT signals.
  logic                       clk;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample      = '0;
  logic                       in_clear       = 1'b0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic                       out_accepted;
  logic signed [AVG_W-1:0]    out_average_q8;
  logic                       out_filled;
  logic [REJ_W-1:0]           out_rejects;
  logic                       cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index      = '0;
  logic [CFG_W-1:0]           cfg_wdata      = '0;

  // Idle rates in percent for the sample and result channels.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Expected results and run statistics.
  avg_result_t expected_results[$];
  int fail_count   = 0;
  int n_results    = 0;
  int n_stored     = 0;
  int n_clears     = 0;
  int peak_rejects = 0;
  int idle_cycles  = 0;

  // Predictor state: ring, pointer, fill flag, sums and registers.
  logic signed [SAMPLE_W-1:0] ring_mem[DEPTH];
  int unsigned                ring_wr_ptr;
  logic                       ring_wrapped;
  logic [REJ_W-1:0]           reject_run;
  longint                     ring_sum;
  longint unsigned            ring_sq_sum;
  logic [3:0]                 tol_mult;
  logic [7:0]                 reject_limit_q;

  moving_average_outlier_reject i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_clear       (in_clear),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_average_q8 (out_average_q8),
    .out_filled     (out_filled),
    .out_rejects    (out_rejects),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Empties the ring, pointer, fill flag and both running sums.
  function automatic void clear_ring();
    for (int i = 0; i < DEPTH; i++) ring_mem[i] = '0;
    ring_wr_ptr  = 0;
    ring_wrapped = 1'b0;
    ring_sum     = 0;
    ring_sq_sum  = 0;
  endfunction

  // Number of entries the average is taken over; one when the ring is empty.
  function automatic longint fill_count();
    if (ring_wrapped) return DEPTH;
    return (ring_wr_ptr > 0) ? longint'(ring_wr_ptr) : 1;
  endfunction

  // Q8 average, truncated toward zero.
  function automatic logic signed [AVG_W-1:0] ring_average_q8();
    if (!ring_wrapped && ring_wr_ptr == 0) return '0;
    return AVG_W'((ring_sum * 256) / fill_count());
  endfunction

  // Exact integer form of ||s| - |avg|| < mult * sigma, both sides squared.
  function automatic bit sigma_test_passes(input longint smp);
    longint       n;
    longint       abs_s;
    longint       abs_sum;
    longint       dev;
    logic [127:0] dev_scaled;
    logic [127:0] sq_scaled;
    logic [127:0] sum_sq;
    logic [127:0] spread_sq;
    logic [127:0] tol_sq;
    n          = fill_count();
    abs_s      = (smp < 0) ? -smp : smp;
    abs_sum    = (ring_sum < 0) ? -ring_sum : ring_sum;
    dev        = abs_s * n - abs_sum;
    dev        = (dev < 0) ? -dev : dev;
    dev_scaled = 128'(dev) * DEPTH;
    sq_scaled  = 128'(ring_sq_sum) * DEPTH;
    sum_sq     = 128'(abs_sum * abs_sum);
    spread_sq  = (sq_scaled >= sum_sq) ? sq_scaled - sum_sq : '0;
    tol_sq     = 128'(tol_mult) * tol_mult * 128'(n) * 128'(n);
    return (dev_scaled * dev_scaled) < (tol_sq * spread_sq);
  endfunction

  // Advances the predictor by one transaction and returns the expected result.
  function automatic avg_result_t predict_step(input logic signed [SAMPLE_W-1:0] smp,
                                               input logic clr);
    avg_result_t res;
    longint      s;
    longint      old;
    int unsigned slot;
    s            = smp;
    res.accepted = 1'b0;
    if (clr) begin
      clear_ring();
    end else if (!ring_wrapped || reject_run > reject_limit_q || sigma_test_passes(s)) begin
      slot          = ring_wr_ptr;
      old           = ring_mem[slot];
      ring_sum      = ring_sum + s - old;
      ring_sq_sum   = ring_sq_sum + longint'(s * s) - longint'(old * old);
      ring_mem[slot] = smp;
      ring_wr_ptr   = (slot + 1) % DEPTH;
      if (ring_wr_ptr == 0) ring_wrapped = 1'b1;
      reject_run    = '0;
      res.accepted  = 1'b1;
    end else if (reject_run < REJ_MAX) begin
      reject_run = reject_run + 1'b1;
    end
    res.average_q8 = ring_average_q8();
    res.filled     = ring_wrapped;
    res.rejects    = reject_run;
    return res;
  endfunction

  // Counts a mismatch and reports it.
  function automatic void check_field(input string name, input longint exp_v,
                                      input longint act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: register writes, sample transactions and result transactions
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    avg_result_t exp_r;
    if (!rst_n) begin
      clear_ring();
      reject_run     = '0;
      tol_mult       = SIGMA_MULT_RST;
      reject_limit_q = REJECT_LIMIT_RST;
    end else begin
      // Results are checked before this edge's sample is predicted.
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          fail_count++;
          $error("result transaction with no expectation");
        end else begin
          exp_r = expected_results.pop_front();
          check_field("accepted", exp_r.accepted, out_accepted);
          check_field("average_q8", exp_r.average_q8, out_average_q8);
          check_field("filled", exp_r.filled, out_filled);
          check_field("rejects", exp_r.rejects, out_rejects);
          if (out_accepted) n_stored++;
          if (out_rejects > peak_rejects) peak_rejects = out_rejects;
        end
      end
      if (in_valid && in_ready) begin
        if (in_clear) n_clears++;
        expected_results.push_back(predict_step(in_sample, in_clear));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SIGMA_MULT:   tol_mult       = cfg_wdata[3:0];
          REG_REJECT_LIMIT: reject_limit_q = cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transaction", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared tasks
  // ---------------------------------------------------------------------------

  // Sends one transaction; returns at the edge where it is accepted.
  task automatic send_item(input logic signed [SAMPLE_W-1:0] smp, input logic clr);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    in_clear  <= clr;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid and waits until every expected result has arrived.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers on consecutive cycles.
  task automatic set_config(input logic [3:0] mult, input logic [7:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SIGMA_MULT;
    cfg_wdata <= CFG_W'(mult);
    @(posedge clk);
    cfg_index <= REG_REJECT_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random traffic around moving operating points, with outliers and clears.
  task automatic run_traffic(input int count, input int clear_permille);
    int   center;
    int   spread;
    int   val;
    logic clr;
    for (int i = 0; i < count; i++) begin
      // New operating point; when clears are enabled, restart from an empty ring half the time.
      if (i % 96 == 0) begin
        center = int'($urandom_range(8388608)) - 4194304;
        case ($urandom_range(3))
          0:       spread = 0;
          1:       spread = 16;
          2:       spread = 4096;
          default: spread = 1 << 20;
        endcase
        if (clear_permille != 0 && $urandom_range(1) == 1)
          send_item(SAMPLE_W'($urandom), 1'b1);
      end
      clr = ($urandom_range(999) < clear_permille);
      if (clr || $urandom_range(99) < 6) begin
        val = int'($signed(SAMPLE_W'($urandom)));
      end else if ($urandom_range(99) < 8) begin
        val = center + ($urandom_range(1) ? 1 : -1) * (spread * 8 + int'($urandom_range(65536)));
      end else begin
        val = center + int'($urandom_range(2 * spread)) - spread;
      end
      if (val > 8388607) val = 8388607;
      if (val < -8388608) val = -8388608;
      send_item(SAMPLE_W'(val), clr);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: extreme samples before the ring wraps, clears, truncation.
  task automatic test_fill_extremes();
    send_item(24'sh7FFFFF, 1'b0);
    send_item(24'sh800000, 1'b0);
    send_item(24'sh000000, 1'b0);
    send_item(-24'sd1, 1'b0);
    send_item(24'sh000001, 1'b0);
    send_item(24'sh7FFFFF, 1'b0);
    send_item(24'sh7FFFFF, 1'b1);
    send_item(24'sh800000, 1'b0);
    send_item(24'sh800000, 1'b0);
    send_item(24'sh800000, 1'b1);
    // Negative averages must truncate toward zero.
    send_item(-24'sd1, 1'b0);
    send_item(24'sh000000, 1'b0);
    send_item(24'sh000000, 1'b0);
    send_item(24'sh555555, 1'b0);
    send_item(24'shAAAAAA, 1'b0);
    send_item(24'sh000000, 1'b1);
    wait_idle();
  endtask

  // Narrow window with a zero limit: every rejection forces the next one in.
  task automatic test_narrow_window();
    set_config(4'd1, 8'd0);
    run_traffic(320, 15);
    wait_idle();
  endtask

  // Widest window with the largest limit: no sample is forced in once the ring has wrapped.
  task automatic test_wide_window();
    set_config(4'd15, 8'd255);
    run_traffic(320, 15);
    wait_idle();
  endtask

  // Zero multiplier: once wrapped everything is rejected and the count saturates.
  task automatic test_reject_saturation();
    set_config(4'd0, 8'd255);
    send_item(SAMPLE_W'($urandom), 1'b1);
    run_traffic(360, 0);
    wait_idle();
  endtask

  // Medium settings where long reject runs end in a forced entry.
  task automatic test_forced_entry();
    set_config(4'd7, 8'd20);
    run_traffic(320, 10);
    wait_idle();
  endtask

  // Random settings, favoring small reject limits.
  task automatic test_random_settings();
    logic [3:0] mult;
    logic [7:0] limit;
    for (int k = 0; k < 3; k++) begin
      mult  = 4'($urandom_range(15));
      limit = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(8));
      set_config(mult, limit);
      run_traffic(210, 12);
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 20;
    rx_idle_pct = 66;
    test_fill_extremes();
    test_narrow_window();
    test_wide_window();

    tx_idle_pct = 66;
    rx_idle_pct = 20;
    test_reject_saturation();
    test_forced_entry();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_settings();

    wait_idle();
    repeat (64) @(posedge clk);
    $display("Checked %0d results: %0d samples stored, %0d clears, peak reject count %0d,",
             n_results, n_stored, n_clears, peak_rejects);
    $display("across multipliers 0 to 15 and reject limits 0 to 255.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
